### hw/rtl/ocrf_pkg.sv
package ocrf_pkg;

  localparam int unsigned POS_W     = 5;
  localparam int unsigned MAX_BYTES = 128;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [7:0]  CRC_PREFIX = 8'hA2;
  localparam logic [7:0]  HDR_ID     = 8'h31;
  localparam logic [7:0]  HDR_TAG    = 8'h10;
  localparam logic [7:0]  VALID_BASE = 8'hF7;
  localparam logic [7:0]  RUMBLE_FLG = 8'h03;
  localparam logic [7:0]  LB_RELEASE = 8'h02;
  localparam logic [7:0]  BRIGHTNESS = 8'h01;

  typedef struct packed {
    logic [3:0] seq_number;
    logic       init_compat;
    logic       lightbar_setup;
    logic       rumble_update;
    logic [7:0] motor_right;
    logic [7:0] motor_left;
    logic [7:0] player_lamps;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [31:0] crc;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  localparam logic [31:0] CRC_SEED = crc_byte(CRC_INIT, CRC_PREFIX);

  function automatic logic [7:0] data_byte(input req_t r, input logic [7:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      8'd0:  b = HDR_ID;
      8'd1:  b = {r.seq_number, 4'h0};
      8'd2:  b = HDR_TAG;
      8'd3:  b = (r.init_compat ? VALID_BASE : 8'h00) | (r.rumble_update ? RUMBLE_FLG : 8'h00);
      8'd4:  b = VALID_BASE;
      8'd5:  b = r.rumble_update ? r.motor_right : 8'h00;
      8'd6:  b = r.rumble_update ? r.motor_left : 8'h00;
      8'd41: b = r.lightbar_setup ? LB_RELEASE : 8'h00;
      8'd44: b = r.lightbar_setup ? LB_RELEASE : 8'h00;
      8'd45: b = BRIGHTNESS;
      8'd46: b = r.player_lamps;
      8'd47: b = r.red_level;
      8'd48: b = r.green_level;
      8'd49: b = r.blue_level;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/controller_output_report_framer_core.sv
// Channel  | Handshake            | Payload
// request  | in_valid / in_ready  | seq_number .. blue_level, one report per transaction
// report   | out_valid / out_ready| report_word, word_position, valid_bytes, last_word
//
// A request runs through the CRC unit at one 32-bit word per cycle. The back emits
// one word per cycle unless the report channel stalls, NW = ceil(REPORT_BYTES/4)
// words per report (20 by default); the slower of the two sets the sustained
// request rate. Reset clears the control state only; a two-entry queue between
// the two halves lets the CRC unit run ahead while the report channel stalls.
module controller_output_report_framer_core #(
  parameter int REPORT_BYTES = 78,
  parameter int CRC_POSITION = 74
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [3:0]                 seq_number,
  input  logic                       init_compat,
  input  logic                       lightbar_setup,
  input  logic                       rumble_update,
  input  logic [7:0]                 motor_right,
  input  logic [7:0]                 motor_left,
  input  logic [7:0]                 player_lamps,
  input  logic [7:0]                 red_level,
  input  logic [7:0]                 green_level,
  input  logic [7:0]                 blue_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                report_word,
  output logic [ocrf_pkg::POS_W-1:0] word_position,
  output logic [2:0]                 valid_bytes,
  output logic                       last_word
);

  ocrf_pkg::req_t   in_req;
  ocrf_pkg::entry_t push_data;
  ocrf_pkg::entry_t pop_data;
  logic             push;
  logic             q_ready;
  logic             q_valid;
  logic             pop;

  assign in_req = '{
    seq_number:     seq_number,
    init_compat:    init_compat,
    lightbar_setup: lightbar_setup,
    rumble_update:  rumble_update,
    motor_right:    motor_right,
    motor_left:     motor_left,
    player_lamps:   player_lamps,
    red_level:      red_level,
    green_level:    green_level,
    blue_level:     blue_level
  };

  ocrf_front #(
    .REPORT_BYTES(REPORT_BYTES),
    .CRC_POSITION(CRC_POSITION)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .push      (push),
    .q_ready   (q_ready),
    .push_data (push_data)
  );

  ocrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  ocrf_back #(
    .REPORT_BYTES(REPORT_BYTES),
    .CRC_POSITION(CRC_POSITION)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .pop           (pop),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .report_word   (report_word),
    .word_position (word_position),
    .valid_bytes   (valid_bytes),
    .last_word     (last_word)
  );

endmodule

### hw/rtl/ocrf_front.sv
module ocrf_front #(
  parameter int REPORT_BYTES = 78,
  parameter int CRC_POSITION = 74
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ocrf_pkg::req_t  in_req,
  output logic            push,
  input  logic            q_ready,
  output ocrf_pkg::entry_t push_data
);

  localparam int TOTAL     = (REPORT_BYTES > 128) ? 128 : REPORT_BYTES;
  localparam int CRCPOS    = (CRC_POSITION > TOTAL) ? TOTAL : CRC_POSITION;
  localparam int CRC_WORDS = (CRCPOS + 3) / 4;
  localparam int CW        = $clog2(CRC_WORDS);

  logic           busy;
  logic           done;
  logic [CW-1:0]  cnt;
  ocrf_pkg::req_t req;
  logic [31:0]    crc;
  logic [31:0]    crc_next;
  logic [7:0]     idx;
  logic           accept;

  always_comb begin
    crc_next = crc;
    idx      = 8'h00;
    for (int i = 0; i < 4; i++) begin
      idx = 8'({cnt, 2'b00}) + 8'(i);
      if (idx < 8'(CRCPOS)) begin
        crc_next = ocrf_pkg::crc_byte(crc_next, ocrf_pkg::data_byte(req, idx));
      end
    end
  end

  assign push      = done && q_ready;
  assign in_ready  = !busy || push;
  assign accept    = in_valid && in_ready;
  assign push_data = '{req: req, crc: ~crc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (busy && !done) begin
        crc <= crc_next;
        if (cnt == CW'(CRC_WORDS - 1)) begin
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end else if (push) begin
        busy <= 1'b0;
        done <= 1'b0;
      end
      if (accept) begin
        req  <= in_req;
        crc  <= ocrf_pkg::CRC_SEED;
        cnt  <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/ocrf_queue.sv
module ocrf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ocrf_pkg::entry_t push_data,
  output logic             q_ready,
  output logic             q_valid,
  input  logic             pop,
  output ocrf_pkg::entry_t pop_data
);

  ocrf_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign q_ready  = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### hw/rtl/ocrf_back.sv
module ocrf_back #(
  parameter int REPORT_BYTES = 78,
  parameter int CRC_POSITION = 74
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       pop,
  input  ocrf_pkg::entry_t           pop_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                report_word,
  output logic [ocrf_pkg::POS_W-1:0] word_position,
  output logic [2:0]                 valid_bytes,
  output logic                       last_word
);

  localparam int TOTAL  = (REPORT_BYTES > 128) ? 128 : REPORT_BYTES;
  localparam int CRCPOS = (CRC_POSITION > TOTAL) ? TOTAL : CRC_POSITION;
  localparam int NW     = (TOTAL + 3) / 4;

  ocrf_pkg::entry_t            cur;
  logic                        active;
  logic [ocrf_pkg::POS_W-1:0]  widx;
  logic                        load;
  logic                        at_last;
  logic [31:0]                 word_next;
  logic [2:0]                  vb_next;
  logic [7:0]                  idx;
  logic [7:0]                  off;
  logic [7:0]                  rem;

  assign at_last = (widx == ocrf_pkg::POS_W'(NW - 1));
  assign load    = active && (!out_valid || out_ready);
  assign pop     = q_valid && (!active || (load && at_last));

  always_comb begin
    word_next = 32'h0;
    idx       = 8'h00;
    off       = 8'h00;
    for (int i = 0; i < 4; i++) begin
      idx = {1'b0, widx, 2'b00} + 8'(i);
      off = idx - 8'(CRCPOS);
      if (idx < 8'(TOTAL) || TOTAL == 128) begin
        if (idx >= 8'(CRCPOS) && off < 8'd4 && CRCPOS < 128) begin
          word_next[8*i +: 8] = cur.crc[{off[1:0], 3'b000} +: 8];
        end else begin
          word_next[8*i +: 8] = ocrf_pkg::data_byte(cur.req, idx);
        end
      end
    end
    rem     = 8'(TOTAL) - {1'b0, widx, 2'b00};
    vb_next = (rem > 8'd4 || rem == 8'd0) ? 3'd4 : rem[2:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
    if (load) begin
      report_word   <= word_next;
      word_position <= widx;
      valid_bytes   <= vb_next;
      last_word     <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (at_last) begin
          active <= 1'b0;
        end else begin
          widx <= widx + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
        widx   <= '0;
      end
    end
  end

endmodule

### hw/rtl/ocrf_checker.sv
module ocrf_checker #(
  parameter int REPORT_BYTES = 78
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [31:0]                report_word,
  input logic [ocrf_pkg::POS_W-1:0] word_position,
  input logic [2:0]                 valid_bytes,
  input logic                       last_word
);

  localparam int TOTAL = (REPORT_BYTES > 128) ? 128 : REPORT_BYTES;
  localparam int NW    = (TOTAL + 3) / 4;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(report_word) && $stable(word_position))
    else $error("Report transaction dropped or changed while stalled.");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> word_position == ocrf_pkg::POS_W'(NW - 1))
    else $error("Last word flagged at the wrong position.");

  a_full_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_word |-> valid_bytes == 3'd4)
    else $error("Word before the last carries fewer than four bytes.");

  a_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_position == '0 |-> report_word[7:0] == ocrf_pkg::HDR_ID)
    else $error("First word does not start with the report identifier.");

endmodule

bind controller_output_report_framer_core ocrf_checker #(
  .REPORT_BYTES(REPORT_BYTES)
) u_ocrf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .report_word   (report_word),
  .word_position (word_position),
  .valid_bytes   (valid_bytes),
  .last_word     (last_word)
);

### tb/sv/controller_output_report_framer_core_test.sv
module controller_output_report_framer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_BYTES = 78;
  localparam int CRC_POSITION = 74;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [31:0]                data;
    logic [ocrf_pkg::POS_W-1:0] pos;
    logic [2:0]                 nbytes;
    logic                       last;
  } report_word_t;

  typedef struct packed {
    ocrf_pkg::req_t req;
    logic           known;
    logic [31:0]    word0;
  } directed_row_t;

  // Fields: seq, init, lightbar, rumble, motor_right, motor_left, lamps, red, green, blue.
  localparam int N_DIRECTED = 14;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{'{4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h00100031},
    '{'{4'hF, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 32'hF710F031},
    '{'{4'h0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'hF7100031},
    '{'{4'h1, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h03101031},
    '{'{4'h8, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h00108031},
    '{'{4'hF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h0010F031},
    '{'{4'h2, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 32'h00102031},
    '{'{4'h0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 32'h00100031},
    '{'{4'h5, 1'b1, 1'b0, 1'b1, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, 32'h0},
    '{'{4'hA, 1'b0, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, 32'h0},
    '{'{4'h3, 1'b0, 1'b1, 1'b1, 8'h80, 8'h01, 8'h1F, 8'h10, 8'h20, 8'h40}, 1'b0, 32'h0},
    '{'{4'hC, 1'b1, 1'b1, 1'b0, 8'h7F, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b0, 32'h0},
    '{'{4'h6, 1'b1, 1'b0, 1'b1, 8'h12, 8'h34, 8'h01, 8'h02, 8'h04, 8'h08}, 1'b0, 32'h0},
    '{'{4'h9, 1'b0, 1'b0, 1'b1, 8'h01, 8'h80, 8'h80, 8'h00, 8'h80, 8'h00}, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] seq_number = '0;
  logic init_compat = 1'b0;
  logic lightbar_setup = 1'b0;
  logic rumble_update = 1'b0;
  logic [7:0] motor_right = '0;
  logic [7:0] motor_left = '0;
  logic [7:0] player_lamps = '0;
  logic [7:0] red_level = '0;
  logic [7:0] green_level = '0;
  logic [7:0] blue_level = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] report_word;
  logic [ocrf_pkg::POS_W-1:0] word_position;
  logic [2:0] valid_bytes;
  logic last_word;

  report_word_t pending_words[$];
  report_word_t got_word;
  report_word_t want_word;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  controller_output_report_framer_core #(
    .REPORT_BYTES(REPORT_BYTES),
    .CRC_POSITION(CRC_POSITION)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .seq_number(seq_number),
    .init_compat(init_compat),
    .lightbar_setup(lightbar_setup),
    .rumble_update(rumble_update),
    .motor_right(motor_right),
    .motor_left(motor_left),
    .player_lamps(player_lamps),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .report_word(report_word),
    .word_position(word_position),
    .valid_bytes(valid_bytes),
    .last_word(last_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] crc32_absorb(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] x;
    x = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ ocrf_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic void predict_report(input ocrf_pkg::req_t r, input logic known,
                                         input logic [31:0] word0);
    logic [7:0] rb [0:131];
    logic [31:0] crc;
    int total;
    int crcpos;
    int nwords;
    int avail;
    report_word_t w;
    total = (REPORT_BYTES > ocrf_pkg::MAX_BYTES) ? ocrf_pkg::MAX_BYTES : REPORT_BYTES;
    crcpos = (CRC_POSITION > total) ? total : CRC_POSITION;
    for (int i = 0; i < 132; i++) begin
      rb[i] = 8'h00;
    end
    rb[0] = ocrf_pkg::HDR_ID;
    rb[1] = {r.seq_number, 4'h0};
    rb[2] = ocrf_pkg::HDR_TAG;
    rb[3] = (r.init_compat ? ocrf_pkg::VALID_BASE : 8'h00) |
            (r.rumble_update ? ocrf_pkg::RUMBLE_FLG : 8'h00);
    rb[4] = ocrf_pkg::VALID_BASE;
    if (r.rumble_update) begin
      rb[5] = r.motor_right;
      rb[6] = r.motor_left;
    end
    if (r.lightbar_setup) begin
      rb[41] = ocrf_pkg::LB_RELEASE;
      rb[44] = ocrf_pkg::LB_RELEASE;
    end
    rb[45] = ocrf_pkg::BRIGHTNESS;
    rb[46] = r.player_lamps;
    rb[47] = r.red_level;
    rb[48] = r.green_level;
    rb[49] = r.blue_level;
    crc = crc32_absorb(ocrf_pkg::CRC_INIT, ocrf_pkg::CRC_PREFIX);
    for (int i = 0; i < crcpos; i++) begin
      crc = crc32_absorb(crc, rb[i]);
    end
    crc = ~crc;
    for (int i = 0; i < 4; i++) begin
      if (crcpos + i < total) begin
        rb[crcpos + i] = crc[8*i +: 8];
      end
    end
    nwords = (total + 3) / 4;
    for (int i = 0; i < nwords; i++) begin
      avail = total - 4 * i;
      if (avail > 4) begin
        avail = 4;
      end
      w.data = {rb[4*i + 3], rb[4*i + 2], rb[4*i + 1], rb[4*i]};
      if (i == 0 && known) begin
        w.data = word0;
      end
      w.pos = i[ocrf_pkg::POS_W-1:0];
      w.nbytes = avail[2:0];
      w.last = (i + 1 == nwords);
      pending_words.push_back(w);
    end
  endfunction

  task automatic offer_request(input ocrf_pkg::req_t r, input logic known,
                               input logic [31:0] word0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    seq_number <= r.seq_number;
    init_compat <= r.init_compat;
    lightbar_setup <= r.lightbar_setup;
    rumble_update <= r.rumble_update;
    motor_right <= r.motor_right;
    motor_left <= r.motor_left;
    player_lamps <= r.player_lamps;
    red_level <= r.red_level;
    green_level <= r.green_level;
    blue_level <= r.blue_level;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_report(r, known, word0);
  endtask

  task automatic send_random(input int count);
    logic [63:0] rnd;
    ocrf_pkg::req_t r;
    for (int n = 0; n < count; n++) begin
      rnd = {$urandom(), $urandom()};
      r = rnd[$bits(ocrf_pkg::req_t)-1:0];
      offer_request(r, 1'b0, 32'h0);
    end
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%s", msg);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_word = '{report_word, word_position, valid_bytes, last_word};
      if (pending_words.size() == 0) begin
        flag_error($sformatf("Unexpected word: data=%h pos=%0d bytes=%0d last=%0d",
                             got_word.data, got_word.pos, got_word.nbytes, got_word.last));
      end else begin
        want_word = pending_words.pop_front();
        if (got_word !== want_word) begin
          flag_error($sformatf(
              {"Mismatch: expected data=%h pos=%0d bytes=%0d last=%0d, ",
               "got data=%h pos=%0d bytes=%0d last=%0d"},
              want_word.data, want_word.pos, want_word.nbytes, want_word.last,
              got_word.data, got_word.pos, got_word.nbytes, got_word.last));
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_request(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].word0);
    end

    // The receiver holds off for a long stretch while requests keep coming.
    hold_asked++;
    send_random(120);

    send_idle_pct = 70;
    recv_stall_pct = 0;
    send_random(110);

    send_idle_pct = 0;
    recv_stall_pct = 70;
    send_random(110);

    send_idle_pct = 15;
    recv_stall_pct = 15;
    send_random(110);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
